// File: design/chte_pkg.sv
// Shared constants and widths for the chained hash table engine.
package chte_pkg;
    localparam int OP_W = 2;
    localparam int ST_W = 2;
    localparam int KEY_W = 31;
    localparam int EPS_W = 31;
    localparam int RATE_W = 16;
    localparam int CFG_W = 5;
    localparam int DEF_BUCKETS = 16;
    localparam int DEF_NODES = 64;
    localparam int RESET_BUCKET_COUNT = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_AVERAGE = 2'd3;

    localparam logic [ST_W-1:0] STAT_DONE = 2'd0;
    localparam logic [ST_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] STAT_FULL = 2'd2;
endpackage

// File: design/chte_ifs.sv
// Request and response channel interfaces of the chained hash table engine.
interface chte_req_if import chte_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [KEY_W-1:0]  key;
    logic [EPS_W-1:0]  episodes_in;
    logic [RATE_W-1:0] rating_in;
    modport source (output valid, operation, key, episodes_in, rating_in, input ready);
    modport sink (input valid, operation, key, episodes_in, rating_in, output ready);
endinterface

interface chte_rsp_if import chte_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [KEY_W-1:0]  key_out;
    logic [EPS_W-1:0]  episodes_out;
    logic [RATE_W-1:0] rating_out;
    modport source (output valid, status, key_out, episodes_out, rating_out, input ready);
    modport sink (input valid, status, key_out, episodes_out, rating_out, output ready);
endinterface

// File: design/chte_div.sv
// Restoring divider that produces one quotient bit per cycle.
module chte_div #(
    parameter int W = 31,
    parameter int V = 7
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [V-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [V-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quo;
    logic [V-1:0]  r_rem;
    logic [V-1:0]  r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [V:0]    n_sh;
    logic [V:0]    n_diff;
    logic          n_ge;

    assign n_sh = {r_rem, r_quo[W-1]};
    assign n_diff = n_sh - {1'b0, r_d};
    assign n_ge = n_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[V-1:0] : n_sh[V-1:0];
            r_quo <= {r_quo[W-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo = r_quo;
    assign o_rem = r_rem;
endmodule

// File: design/chained_hash_table_engine_top.sv
// Top level of the chained hash table engine.
// Each request passes the divider (key modulo bucket count selects the bucket); lookup and
// delete then walk the chain, and an average divides the rating sum by the node count.
// An insert into a full pool or an average of an empty table skips the divider.
// One request is handled at a time; the bit-serial divider and the chain walk set the rate.
// After reset every bucket head is cleared, in S_CLR, before the first request is accepted.
module chained_hash_table_engine_top import chte_pkg::*; #(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int NODES = DEF_NODES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    chte_req_if.sink         i_req,
    chte_rsp_if.source       o_rsp
);
    localparam int NW = $clog2(NODES + 1);
    localparam int AW = $clog2(NODES);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SW = RATE_W + NW;
    localparam int DW = (SW > KEY_W) ? SW : KEY_W;
    localparam int VW = (NW > CFG_W) ? NW : CFG_W;
    localparam int RBC = (RESET_BUCKET_COUNT > BUCKETS) ? BUCKETS : RESET_BUCKET_COUNT;
    localparam logic [NW-1:0] NONE = NW'(NODES);

    localparam logic [3:0] S_CLR = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DIV = 4'd2;
    localparam logic [3:0] S_HREQ = 4'd3;
    localparam logic [3:0] S_HEAD = 4'd4;
    localparam logic [3:0] S_READ = 4'd5;
    localparam logic [3:0] S_WALK = 4'd6;
    localparam logic [3:0] S_DEL1 = 4'd7;
    localparam logic [3:0] S_DEL2 = 4'd8;
    localparam logic [3:0] S_FIN = 4'd9;

    logic [NW-1:0]     m_heads [BUCKETS];
    logic [NW-1:0]     m_links [NODES];
    logic [KEY_W-1:0]  m_key [NODES];
    logic [EPS_W-1:0]  m_eps [NODES];
    logic [RATE_W-1:0] m_rat [NODES];

    logic [3:0]        r_state;
    logic [BW-1:0]     r_clr;
    logic [CFG_W-1:0]  r_bc;
    logic [OP_W-1:0]   r_op;
    logic [KEY_W-1:0]  r_key;
    logic [EPS_W-1:0]  r_eps;
    logic [RATE_W-1:0] r_rat;
    logic [BW-1:0]     r_bkt;
    logic [NW-1:0]     r_cur;
    logic [NW-1:0]     r_prev;
    logic [NW-1:0]     r_free;
    logic [NW-1:0]     r_fresh;
    logic [SW-1:0]     r_sum;
    logic [NW-1:0]     r_cnt;
    logic [NW-1:0]     r_hq;
    logic [NW-1:0]     r_lq;
    logic [KEY_W-1:0]  r_nk;
    logic [EPS_W-1:0]  r_ne;
    logic [RATE_W-1:0] r_nr;
    logic [ST_W-1:0]   r_st;
    logic [KEY_W-1:0]  r_ko;
    logic [EPS_W-1:0]  r_eo;
    logic [RATE_W-1:0] r_ro;
    logic              r_ovalid;
    logic [ST_W-1:0]   r_ost;
    logic [KEY_W-1:0]  r_oko;
    logic [EPS_W-1:0]  r_oeo;
    logic [RATE_W-1:0] r_oro;

    logic              n_acc;
    logic              n_div_start;
    logic [DW-1:0]     n_dividend;
    logic [VW-1:0]     n_divisor;
    logic              div_done;
    logic [DW-1:0]     div_quo;
    logic [VW-1:0]     div_rem;
    logic [10:0]       n_cfg_ext;
    logic [CFG_W-1:0]  n_bc;
    logic              n_ins;
    logic              n_del;

    logic              h_we;
    logic [BW-1:0]     h_wa;
    logic [NW-1:0]     h_wd;
    logic              l_we;
    logic [AW-1:0]     l_wa;
    logic [NW-1:0]     l_wd;
    logic              l_re;
    logic [AW-1:0]     l_ra;

    assign i_req.ready = (r_state == S_IDLE);
    assign n_acc = i_req.valid && (r_state == S_IDLE);
    assign n_ins = (r_op == OP_INSERT);
    assign n_del = (r_op == OP_DELETE);

    always_comb begin
        n_div_start = 1'b0;
        n_dividend = DW'(i_req.key);
        n_divisor = VW'(r_bc);
        if (n_acc) begin
            case (i_req.operation)
                OP_INSERT: n_div_start = (r_free != NONE);
                OP_AVERAGE: begin
                    n_div_start = (r_cnt != '0);
                    n_dividend = DW'(r_sum);
                    n_divisor = VW'(r_cnt);
                end
                default: n_div_start = 1'b1;
            endcase
        end
    end

    chte_div #(.W(DW), .V(VW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_cfg_ext = 11'(i_cfg_data);
        if (n_cfg_ext == '0) begin
            n_bc = CFG_W'(1);
        end else if (n_cfg_ext > 11'(BUCKETS)) begin
            n_bc = CFG_W'(BUCKETS);
        end else begin
            n_bc = i_cfg_data;
        end
    end

    always_comb begin
        h_we = 1'b0;
        h_wa = r_bkt;
        h_wd = r_lq;
        l_we = 1'b0;
        l_wa = r_cur[AW-1:0];
        l_wd = r_free;
        l_re = 1'b0;
        l_ra = r_cur[AW-1:0];
        case (r_state)
            S_CLR: begin
                h_we = 1'b1;
                h_wa = r_clr;
                h_wd = NONE;
            end
            S_IDLE: begin
                l_re = n_acc && (i_req.operation == OP_INSERT) && (r_free != NONE);
                l_ra = r_free[AW-1:0];
            end
            S_HEAD: begin
                if (n_ins) begin
                    h_we = 1'b1;
                    h_wd = r_free;
                    l_we = 1'b1;
                    l_wa = r_free[AW-1:0];
                    l_wd = r_hq;
                end
            end
            S_READ: l_re = 1'b1;
            S_DEL1: begin
                if (r_prev == NONE) begin
                    h_we = 1'b1;
                end else begin
                    l_we = 1'b1;
                    l_wa = r_prev[AW-1:0];
                    l_wd = r_lq;
                end
            end
            S_DEL2: l_we = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            m_heads[h_wa] <= h_wd;
        end
        if (r_state == S_HREQ) begin
            r_hq <= m_heads[r_bkt];
        end
        if (l_we) begin
            m_links[l_wa] <= l_wd;
        end
        if (l_re) begin
            r_lq <= m_links[l_ra];
        end
        if ((r_state == S_HEAD) && n_ins) begin
            m_key[r_free[AW-1:0]] <= r_key;
            m_eps[r_free[AW-1:0]] <= r_eps;
            m_rat[r_free[AW-1:0]] <= r_rat;
        end
        if (r_state == S_READ) begin
            r_nk <= m_key[r_cur[AW-1:0]];
            r_ne <= m_eps[r_cur[AW-1:0]];
            r_nr <= m_rat[r_cur[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_bc <= CFG_W'(RBC);
            r_free <= '0;
            r_fresh <= '0;
            r_sum <= '0;
            r_cnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we && (r_cnt == '0)) begin
                r_bc <= n_bc;
            end
            if ((r_state == S_FIN) && (!r_ovalid || o_rsp.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == BW'(BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (n_acc) begin
                        r_op <= i_req.operation;
                        r_key <= i_req.key;
                        r_eps <= i_req.episodes_in;
                        r_rat <= i_req.rating_in;
                        r_ko <= '0;
                        r_eo <= '0;
                        r_ro <= '0;
                        if (!n_div_start && (i_req.operation == OP_INSERT)) begin
                            r_st <= STAT_FULL;
                        end else begin
                            r_st <= STAT_DONE;
                        end
                        if (n_div_start) begin
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_op == OP_AVERAGE) begin
                            r_ro <= div_quo[RATE_W-1:0];
                            r_state <= S_FIN;
                        end else begin
                            r_bkt <= BW'(div_rem);
                            r_state <= S_HREQ;
                        end
                    end
                end
                S_HREQ: r_state <= S_HEAD;
                S_HEAD: begin
                    if (n_ins) begin
                        if (r_free == r_fresh) begin
                            r_free <= r_free + 1'b1;
                            r_fresh <= r_fresh + 1'b1;
                        end else begin
                            r_free <= r_lq;
                        end
                        r_sum <= r_sum + SW'(r_rat);
                        r_cnt <= r_cnt + 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_prev <= NONE;
                        r_cur <= r_hq;
                        if (r_hq == NONE) begin
                            r_st <= STAT_NOT_FOUND;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: r_state <= S_WALK;
                S_WALK: begin
                    if (r_nk == r_key) begin
                        r_ko <= r_nk;
                        r_eo <= r_ne;
                        r_ro <= r_nr;
                        r_state <= n_del ? S_DEL1 : S_FIN;
                    end else begin
                        r_prev <= r_cur;
                        r_cur <= r_lq;
                        if (r_lq == NONE) begin
                            r_st <= STAT_NOT_FOUND;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_DEL1: r_state <= S_DEL2;
                S_DEL2: begin
                    r_free <= r_cur;
                    r_sum <= r_sum - SW'(r_nr);
                    r_cnt <= r_cnt - 1'b1;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && (!r_ovalid || o_rsp.ready)) begin
            r_ost <= r_st;
            r_oko <= r_ko;
            r_oeo <= r_eo;
            r_oro <= r_ro;
        end
    end

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.status = r_ost;
    assign o_rsp.key_out = r_oko;
    assign o_rsp.episodes_out = r_oeo;
    assign o_rsp.rating_out = r_oro;
endmodule
